// File: rtl/checksum_frame_receiver_assert.svh
// Assertion macros used by the checker file.
`ifndef CHECKSUM_FRAME_RECEIVER_ASSERT_SVH
`define CHECKSUM_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checksum_frame_receiver: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checksum_frame_receiver: next-cycle check failed");

`endif

// File: rtl/cfr_pkg.sv
`default_nettype none
package cfr_pkg;

  localparam int TEXT_LEN_DEF = 8;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_ADDR_W   = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_START_ONE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_TWO = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_END_ONE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_END_TWO   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TEXT_LEN  = 3'd4;

  localparam logic [7:0] RST_START_ONE = 8'd170;
  localparam logic [7:0] RST_START_TWO = 8'd85;
  localparam logic [7:0] RST_END_ONE   = 8'd13;
  localparam logic [7:0] RST_END_TWO   = 8'd10;
  localparam logic [5:0] RST_TEXT_LEN  = 6'd8;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FRAME_ERR = 2'd1;
  localparam logic [1:0] ST_SUM_ERR   = 2'd2;

  typedef struct packed {
    logic [7:0] start_one;
    logic [7:0] start_two;
    logic [7:0] end_one;
    logic [7:0] end_two;
    logic [5:0] text_len;
  } cfr_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic [15:0] value_one;
    logic [15:0] value_two;
    logic        flag;
  } cfr_hdr_t;

endpackage
`default_nettype wire

// File: rtl/cfr_front.sv
`default_nettype none
module cfr_front import cfr_pkg::*; #(
  parameter int TEXT_LEN = TEXT_LEN_DEF,
  parameter int IDX_W    = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cfr_cfg_t                      cfg,
  input  wire logic                          in_push,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               in_full,
  input  wire logic                          q_full,
  output logic                               q_push,
  output cfr_hdr_t                           q_hdr,
  output logic [IDX_W-1:0]                   q_last_idx,
  output logic [TEXT_LEN-1:0][7:0]           q_text
);

  localparam int FRM_BYTES  = TEXT_LEN + 11;
  localparam int CNT_W      = $clog2(FRM_BYTES);
  localparam int POS_START2 = 1;
  localparam int POS_CMD    = 2;
  localparam int POS_V1_LO  = 3;
  localparam int POS_V1_HI  = 4;
  localparam int POS_V2_LO  = 5;
  localparam int POS_V2_HI  = 6;
  localparam int POS_FLAG   = 7;
  localparam int POS_TEXT   = 8;
  localparam int POS_SUM    = TEXT_LEN + 8;
  localparam int POS_END1   = TEXT_LEN + 9;
  localparam int POS_LAST   = TEXT_LEN + 10;

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      start_ok_r, start_ok_nxt;
  logic                      end_ok_r, end_ok_nxt;
  logic [7:0]                sum_r;
  logic [7:0]                rsum_r;
  logic [7:0]                cmd_r;
  logic [15:0]               v1_r;
  logic [15:0]               v2_r;
  logic                      flag_r;
  logic [TEXT_LEN-1:0][7:0]  text_r;

  logic                      accept;
  logic                      at_last;
  logic                      text_wr;
  logic [IDX_W-1:0]          text_idx;
  logic                      frame_bad;
  logic                      sum_bad;
  logic [5:0]                len_clamp;

  assign at_last = (cnt_r == CNT_W'(POS_LAST));
  assign in_full = at_last && q_full;
  assign accept  = in_push && !in_full;

  assign text_wr  = (cnt_r >= CNT_W'(POS_TEXT)) && (cnt_r < CNT_W'(POS_SUM));
  assign text_idx = IDX_W'(cnt_r - CNT_W'(POS_TEXT));

  assign frame_bad = !start_ok_r || !end_ok_r || (in_rx_byte != cfg.end_two);
  assign sum_bad   = (sum_r != rsum_r);
  assign len_clamp = (cfg.text_len > 6'(TEXT_LEN)) ? 6'(TEXT_LEN) : cfg.text_len;

  always_comb begin
    cnt_nxt      = cnt_r;
    start_ok_nxt = start_ok_r;
    end_ok_nxt   = end_ok_r;
    if (accept) begin
      cnt_nxt = at_last ? '0 : cnt_r + CNT_W'(1);
      if (cnt_r == '0) begin
        start_ok_nxt = (in_rx_byte == cfg.start_one);
      end
      if (cnt_r == CNT_W'(POS_START2)) begin
        start_ok_nxt = start_ok_r && (in_rx_byte == cfg.start_two);
      end
      if (cnt_r == CNT_W'(POS_END1)) begin
        end_ok_nxt = (in_rx_byte == cfg.end_one);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      start_ok_r <= 1'b0;
      end_ok_r   <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      start_ok_r <= start_ok_nxt;
      end_ok_r   <= end_ok_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cnt_r == CNT_W'(POS_START2)) begin
        sum_r <= 8'd0;
      end else if ((cnt_r >= CNT_W'(POS_CMD)) && (cnt_r < CNT_W'(POS_SUM))) begin
        sum_r <= sum_r + in_rx_byte;
      end
      if (cnt_r == CNT_W'(POS_CMD))   cmd_r       <= in_rx_byte;
      if (cnt_r == CNT_W'(POS_V1_LO)) v1_r[7:0]   <= in_rx_byte;
      if (cnt_r == CNT_W'(POS_V1_HI)) v1_r[15:8]  <= in_rx_byte;
      if (cnt_r == CNT_W'(POS_V2_LO)) v2_r[7:0]   <= in_rx_byte;
      if (cnt_r == CNT_W'(POS_V2_HI)) v2_r[15:8]  <= in_rx_byte;
      if (cnt_r == CNT_W'(POS_FLAG))  flag_r      <= (in_rx_byte != 8'd0);
      if (text_wr)                    text_r[text_idx] <= in_rx_byte;
      if (cnt_r == CNT_W'(POS_SUM))   rsum_r      <= in_rx_byte;
    end
  end

  // verdict on the closing byte; a good frame with no text to copy is dropped
  always_comb begin
    q_push     = accept && at_last && (frame_bad || sum_bad || (len_clamp != 6'd0));
    q_hdr      = '0;
    q_last_idx = '0;
    q_text     = '0;
    if (frame_bad) begin
      q_hdr.status = ST_FRAME_ERR;
    end else if (sum_bad) begin
      q_hdr.status = ST_SUM_ERR;
    end else begin
      q_hdr.status    = ST_OK;
      q_hdr.command   = cmd_r;
      q_hdr.value_one = v1_r;
      q_hdr.value_two = v2_r;
      q_hdr.flag      = flag_r;
      q_last_idx      = IDX_W'(len_clamp - 6'd1);
      q_text          = text_r;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cfr_queue.sv
`default_nettype none
module cfr_queue import cfr_pkg::*; #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output logic               full,
  input  wire logic          pop,
  output logic [DW-1:0]      pop_data,
  output logic               empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0]    mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cfr_back.sv
`default_nettype none
module cfr_back import cfr_pkg::*; #(
  parameter int TEXT_LEN = TEXT_LEN_DEF,
  parameter int IDX_W    = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_empty,
  input  wire cfr_hdr_t                q_hdr,
  input  wire logic [IDX_W-1:0]        q_last_idx,
  input  wire logic [TEXT_LEN-1:0][7:0] q_text,
  output logic                         q_pop,
  output logic                         out_empty,
  input  wire logic                    out_pop,
  output logic [1:0]                   out_status,
  output logic [7:0]                   out_command,
  output logic [15:0]                  out_value_one,
  output logic [15:0]                  out_value_two,
  output logic                         out_flag_bit,
  output logic [7:0]                   out_text_byte,
  output logic [4:0]                   out_text_index,
  output logic                         out_last
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             take;

  assign out_empty      = q_empty;
  assign take           = out_pop && !q_empty;
  assign out_status     = q_hdr.status;
  assign out_command    = q_hdr.command;
  assign out_value_one  = q_hdr.value_one;
  assign out_value_two  = q_hdr.value_two;
  assign out_flag_bit   = q_hdr.flag;
  assign out_text_byte  = q_text[idx_r];
  assign out_text_index = 5'(idx_r);
  assign out_last       = (idx_r == q_last_idx);

  // release the frame entry only after its final item goes out
  assign q_pop = take && out_last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = out_last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/checksum_frame_receiver.sv
// Channel  Handshake                Payload
// in       in_push / in_full        in_rx_byte
// out      out_pop / out_empty      status, command, value_one/two, flag_bit,
//                                   text_byte, text_index, last
// cfg      cfg_valid / cfg_ready    cfg_addr, cfg_data
//
// One byte is taken per cycle while in_full is low; a frame is TEXT_LEN + 11 bytes.
// A frame's verdict enters a two-entry descriptor queue on its closing byte;
// the result side then gives one item per cycle while out_pop is high, up to
// TEXT_LEN per frame. in_full rises only on a closing byte with the queue full.
// cfg_ready is always high. Reset (rst_n low, synchronous) empties the queue,
// restarts byte counting and loads the default register values.
`default_nettype none
module checksum_frame_receiver import cfr_pkg::*; #(
  parameter int TEXT_LEN = TEXT_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [7:0]            in_rx_byte,
  output logic                       in_full,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [1:0]                 out_status,
  output logic [7:0]                 out_command,
  output logic [15:0]                out_value_one,
  output logic [15:0]                out_value_two,
  output logic                       out_flag_bit,
  output logic [7:0]                 out_text_byte,
  output logic [4:0]                 out_text_index,
  output logic                       out_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [7:0]            cfg_data
);

  localparam int IDX_W = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1;
  localparam int HDR_W = $bits(cfr_hdr_t);
  localparam int TXT_W = TEXT_LEN * 8;
  localparam int DW    = HDR_W + IDX_W + TXT_W;

  cfr_cfg_t                 cfg_r, cfg_nxt;
  cfr_hdr_t                 f_hdr, b_hdr;
  logic [IDX_W-1:0]         f_last_idx, b_last_idx;
  logic [TEXT_LEN-1:0][7:0] f_text, b_text;
  logic                     f_push;
  logic                     q_full;
  logic                     q_empty;
  logic                     q_pop;
  logic [DW-1:0]            q_wdata;
  logic [DW-1:0]            q_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        CFG_START_ONE: cfg_nxt.start_one = cfg_data;
        CFG_START_TWO: cfg_nxt.start_two = cfg_data;
        CFG_END_ONE:   cfg_nxt.end_one   = cfg_data;
        CFG_END_TWO:   cfg_nxt.end_two   = cfg_data;
        CFG_TEXT_LEN:  cfg_nxt.text_len  = cfg_data[5:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_one <= RST_START_ONE;
      cfg_r.start_two <= RST_START_TWO;
      cfg_r.end_one   <= RST_END_ONE;
      cfg_r.end_two   <= RST_END_TWO;
      cfg_r.text_len  <= RST_TEXT_LEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cfr_front #(
    .TEXT_LEN (TEXT_LEN),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .q_full     (q_full),
    .q_push     (f_push),
    .q_hdr      (f_hdr),
    .q_last_idx (f_last_idx),
    .q_text     (f_text)
  );

  assign q_wdata    = {f_hdr, f_last_idx, f_text};
  assign b_hdr      = q_rdata[DW-1 -: HDR_W];
  assign b_last_idx = q_rdata[TXT_W +: IDX_W];
  assign b_text     = q_rdata[TXT_W-1:0];

  cfr_queue #(
    .DW (DW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  cfr_back #(
    .TEXT_LEN (TEXT_LEN),
    .IDX_W    (IDX_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_hdr          (b_hdr),
    .q_last_idx     (b_last_idx),
    .q_text         (b_text),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_command    (out_command),
    .out_value_one  (out_value_one),
    .out_value_two  (out_value_two),
    .out_flag_bit   (out_flag_bit),
    .out_text_byte  (out_text_byte),
    .out_text_index (out_text_index),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

// File: rtl/cfr_checker.sv
`default_nettype none
`include "checksum_frame_receiver_assert.svh"
module cfr_checker import cfr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_command,
  input wire logic [15:0] out_value_one,
  input wire logic [15:0] out_value_two,
  input wire logic        out_flag_bit,
  input wire logic [7:0]  out_text_byte,
  input wire logic [4:0]  out_text_index,
  input wire logic        out_last
);

  // an error verdict is a single, closing item with cleared fields
  `CFR_ASSERT_NOW(a_err_single, !out_empty && (out_status != ST_OK), out_last && (out_text_index == 5'd0) && (out_text_byte == 8'd0))
  `CFR_ASSERT_NOW(a_err_clear, !out_empty && (out_status != ST_OK), (out_command == 8'd0) && (out_value_one == 16'd0) && (out_value_two == 16'd0) && !out_flag_bit)
  // text items of one frame follow one another in order
  `CFR_ASSERT_NEXT(a_idx_step, !out_empty && out_pop && !out_last, !out_empty && (out_text_index == $past(out_text_index) + 5'd1) && (out_status == ST_OK))
  // a waiting item holds while not taken
  `CFR_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_status) && $stable(out_text_byte) && $stable(out_text_index) && $stable(out_last))

endmodule

bind checksum_frame_receiver cfr_checker u_cfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_status     (out_status),
  .out_command    (out_command),
  .out_value_one  (out_value_one),
  .out_value_two  (out_value_two),
  .out_flag_bit   (out_flag_bit),
  .out_text_byte  (out_text_byte),
  .out_text_index (out_text_index),
  .out_last       (out_last)
);
`default_nettype wire

// File: test/checksum_frame_receiver_tb.sv
`timescale 1ns / 1ps
module checksum_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int FRM_BYTES   = TEXT_LEN_DEF + 11;
  localparam int PLD_BYTES   = TEXT_LEN_DEF + 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int STALL_LEN   = 600;
  localparam int ITEM_TARGET = 320;

  typedef enum int {
    FRM_GOOD, FRM_BAD_START_ONE, FRM_BAD_START_TWO, FRM_BAD_END_ONE,
    FRM_BAD_END_TWO, FRM_BAD_SUM, FRM_NOISE
  } frame_kind_e;

  typedef enum int { FILL_RANDOM, FILL_ONES, FILL_ZERO } fill_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic [15:0] value_one;
    logic [15:0] value_two;
    logic        flag_bit;
    logic [7:0]  text_byte;
    logic [4:0]  text_index;
    logic        last;
  } rx_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_push    = 1'b0;
  logic [7:0]            in_rx_byte = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop    = 1'b0;
  logic [1:0]            out_status;
  logic [7:0]            out_command;
  logic [15:0]           out_value_one;
  logic [15:0]           out_value_two;
  logic                  out_flag_bit;
  logic [7:0]            out_text_byte;
  logic [4:0]            out_text_index;
  logic                  out_last;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [7:0]            cfg_data   = '0;

  checksum_frame_receiver i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_rx_byte     (in_rx_byte),
    .in_full        (in_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_command    (out_command),
    .out_value_one  (out_value_one),
    .out_value_two  (out_value_two),
    .out_flag_bit   (out_flag_bit),
    .out_text_byte  (out_text_byte),
    .out_text_index (out_text_index),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // shadow registers
  logic [7:0] want_start_one = RST_START_ONE;
  logic [7:0] want_start_two = RST_START_TWO;
  logic [7:0] want_end_one   = RST_END_ONE;
  logic [7:0] want_end_two   = RST_END_TWO;
  logic [5:0] copy_len       = RST_TEXT_LEN;

  // shadow frame state
  int         frame_pos    = 0;
  logic [7:0] payload_sum  = '0;
  logic       start_good   = 1'b0;
  logic       end_one_good = 1'b0;
  logic [7:0] sent_sum     = '0;
  logic [7:0] hdr_command  = '0;
  logic [15:0] hdr_value_one = '0;
  logic [15:0] hdr_value_two = '0;
  logic       hdr_flag     = 1'b0;
  logic [7:0] text_shadow [TEXT_LEN_DEF];

  logic [7:0] rx_pending [$];
  rx_result_t frame_results [$];
  logic [7:0] frame_payload [PLD_BYTES];

  int   fail_count     = 0;
  int   cycle_count    = 0;
  int   sent_bytes     = 0;
  int   in_gap         = 0;
  int   out_gap        = 0;
  int   stall_left     = 0;
  logic long_stall_req = 1'b0;
  logic rx_hold        = 1'b0;
  logic calm           = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_verdict(input logic [1:0] st);
    rx_result_t r;
    r = '0;
    r.status = st;
    r.last   = 1'b1;
    frame_results.push_back(r);
  endtask

  // advance the frame shadow by one received byte
  task automatic absorb_rx_byte(input logic [7:0] b);
    int         o;
    int         n;
    rx_result_t r;
    if (frame_pos == 0) begin
      start_good = (b == want_start_one);
    end else if (frame_pos == 1) begin
      start_good  = start_good && (b == want_start_two);
      payload_sum = '0;
    end else if (frame_pos < 2 + PLD_BYTES) begin
      o = frame_pos - 2;
      payload_sum = payload_sum + b;
      case (o)
        0: hdr_command = b;
        1: hdr_value_one[7:0] = b;
        2: hdr_value_one[15:8] = b;
        3: hdr_value_two[7:0] = b;
        4: hdr_value_two[15:8] = b;
        5: hdr_flag = (b != 8'd0);
        default: text_shadow[o - 6] = b;
      endcase
    end else if (frame_pos == 2 + PLD_BYTES) begin
      sent_sum = b;
    end else if (frame_pos == 3 + PLD_BYTES) begin
      end_one_good = (b == want_end_one);
    end

    if (frame_pos + 1 < FRM_BYTES) begin
      frame_pos++;
    end else begin
      frame_pos = 0;
      if (!start_good || !end_one_good || b != want_end_two) begin
        push_verdict(ST_FRAME_ERR);
      end else if (payload_sum != sent_sum) begin
        push_verdict(ST_SUM_ERR);
      end else begin
        n = (copy_len > TEXT_LEN_DEF) ? TEXT_LEN_DEF : int'(copy_len);
        for (int i = 0; i < n; i++) begin
          r.status     = ST_OK;
          r.command    = hdr_command;
          r.value_one  = hdr_value_one;
          r.value_two  = hdr_value_two;
          r.flag_bit   = hdr_flag;
          r.text_byte  = text_shadow[i];
          r.text_index = 5'(i);
          r.last       = (i + 1 == n);
          frame_results.push_back(r);
        end
      end
    end
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : drive_rx
    logic acc;
    acc = in_push && !in_full;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (acc) begin
        absorb_rx_byte(in_rx_byte);
        in_gap = pick_gap();
      end
      // hold the offered item while the block is full
      if (!in_push || acc) begin
        if (in_gap > 0) begin
          in_gap--;
          in_push <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          in_rx_byte <= rx_pending.pop_front();
          in_push    <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // long hold-off of the result side, counted here in cycles
  always @(posedge clk) begin : hold_off_rx
    if (long_stall_req) begin
      stall_left     = STALL_LEN;
      long_stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      rx_hold <= 1'b1;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch_results
    rx_result_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (frame_results.size() == 0) begin
          $error("result with no expectation: status %0d", out_status);
          fail_count++;
        end else begin
          e = frame_results.pop_front();
          cmp_field("status", e.status, out_status);
          cmp_field("command", e.command, out_command);
          cmp_field("value_one", e.value_one, out_value_one);
          cmp_field("value_two", e.value_two, out_value_two);
          cmp_field("flag_bit", e.flag_bit, out_flag_bit);
          cmp_field("text_byte", e.text_byte, out_text_byte);
          cmp_field("text_index", e.text_index, out_text_index);
          cmp_field("last", e.last, out_last);
        end
        out_gap = pick_gap();
      end
      if (rx_hold) begin
        out_pop <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic program_regs(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] e1, input logic [7:0] e2,
                              input logic [5:0] tl);
    logic [CFG_ADDR_W-1:0] idx [5];
    logic [7:0]            val [5];
    int                    i;
    idx = '{CFG_START_ONE, CFG_START_TWO, CFG_END_ONE, CFG_END_TWO, CFG_TEXT_LEN};
    val = '{s1, s2, e1, e2, {2'b00, tl}};
    i = 0;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx[0];
    cfg_data  <= val[0];
    while (i < 5) begin
      @(posedge clk);
      if (cfg_ready) begin
        case (idx[i])
          CFG_START_ONE: want_start_one = val[i];
          CFG_START_TWO: want_start_two = val[i];
          CFG_END_ONE:   want_end_one   = val[i];
          CFG_END_TWO:   want_end_two   = val[i];
          CFG_TEXT_LEN:  copy_len       = val[i][5:0];
          default: ;
        endcase
        i++;
        if (i < 5) begin
          cfg_addr <= idx[i];
          cfg_data <= val[i];
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  endtask

  task automatic fill_payload(input fill_e mode);
    for (int i = 0; i < PLD_BYTES; i++) begin
      case (mode)
        FILL_ONES: frame_payload[i] = 8'hFF;
        FILL_ZERO: frame_payload[i] = 8'h00;
        default:   frame_payload[i] = 8'($urandom);
      endcase
    end
    // the flag byte is zero often enough to see both outcomes
    if (mode == FILL_RANDOM && $urandom_range(0, 9) < 4) frame_payload[5] = 8'h00;
  endtask

  function automatic logic [7:0] spoil(input logic [7:0] b);
    return b + 8'($urandom_range(1, 255));
  endfunction

  task automatic queue_frame(input frame_kind_e kind);
    logic [7:0] sum;
    sum = '0;
    if (kind == FRM_NOISE) begin
      for (int i = 0; i < FRM_BYTES; i++) rx_pending.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < PLD_BYTES; i++) sum = sum + frame_payload[i];
      rx_pending.push_back(kind == FRM_BAD_START_ONE ? spoil(want_start_one) : want_start_one);
      rx_pending.push_back(kind == FRM_BAD_START_TWO ? spoil(want_start_two) : want_start_two);
      for (int i = 0; i < PLD_BYTES; i++) rx_pending.push_back(frame_payload[i]);
      rx_pending.push_back(kind == FRM_BAD_SUM ? spoil(sum) : sum);
      rx_pending.push_back(kind == FRM_BAD_END_ONE ? spoil(want_end_one) : want_end_one);
      rx_pending.push_back(kind == FRM_BAD_END_TWO ? spoil(want_end_two) : want_end_two);
    end
    sent_bytes += FRM_BYTES;
  endtask

  task automatic random_frame_to_queue(input frame_kind_e kind);
    fill_payload(FILL_RANDOM);
    queue_frame(kind);
  endtask

  // wait for every item to go in and every result to come out, then settle
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_pending.size() != 0 || in_push || frame_results.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_marker();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [5:0] pick_copy_len();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return 6'd1;
    if (r == 1) return 6'd32;
    if (r == 2) return 6'd8;
    return 6'($urandom_range(1, 32));
  endfunction

  initial begin
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: extreme payloads, a bad start and a bad sum
    fill_payload(FILL_ONES);
    queue_frame(FRM_GOOD);
    fill_payload(FILL_ZERO);
    queue_frame(FRM_GOOD);
    random_frame_to_queue(FRM_BAD_START_ONE);
    random_frame_to_queue(FRM_BAD_SUM);
    wait_drained();

    // copy length above the text field is clamped
    program_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 6'd32);
    random_frame_to_queue(FRM_GOOD);
    random_frame_to_queue(FRM_BAD_END_TWO);
    random_frame_to_queue(FRM_BAD_END_ONE);
    random_frame_to_queue(FRM_BAD_START_TWO);
    wait_drained();

    program_regs(8'hFF, 8'h00, 8'h00, 8'hFF, 6'd1);
    random_frame_to_queue(FRM_GOOD);
    random_frame_to_queue(FRM_GOOD);
    wait_drained();

    // zero copy length swallows a good frame
    program_regs(RST_START_ONE, RST_START_TWO, RST_END_ONE, RST_END_TWO, 6'd0);
    random_frame_to_queue(FRM_GOOD);
    random_frame_to_queue(FRM_BAD_SUM);
    wait_drained();

    // hold the receiver off while the sender keeps pushing
    program_regs(pick_marker(), pick_marker(), pick_marker(), pick_marker(), 6'd8);
    calm           = 1'b1;
    long_stall_req = 1'b1;
    for (int f = 0; f < 3; f++) random_frame_to_queue(FRM_GOOD);
    wait_drained();
    calm = 1'b0;

    while (sent_bytes + FRM_BYTES <= ITEM_TARGET) begin
      program_regs(pick_marker(), pick_marker(), pick_marker(), pick_marker(),
                   pick_copy_len());
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 99);
        if (r < 65) random_frame_to_queue(FRM_GOOD);
        else if (r < 90) random_frame_to_queue(frame_kind_e'($urandom_range(1, 5)));
        else queue_frame(FRM_NOISE);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/cfr_pkg.sv
rtl/cfr_front.sv
rtl/cfr_queue.sv
rtl/cfr_back.sv
rtl/checksum_frame_receiver.sv
rtl/cfr_checker.sv
test/checksum_frame_receiver_tb.sv
